### rtl/sasd_pkg.sv
// Shared types and constants of the short address stream decoder.
`timescale 1ns / 1ps

package sasd_pkg;

	// Descriptor ranges and special byte values.
	localparam logic [7:0] DESC_ONE_MAX  = 8'hDC;
	localparam logic [7:0] DESC_TWO_MIN  = 8'hDD;
	localparam logic [7:0] DESC_TWO_MAX  = 8'hF0;
	localparam logic [7:0] DESC_THREE    = 8'hF1;
	localparam logic [7:0] DESC_FIVE     = 8'hF2;
	localparam logic [7:0] DESC_PUBLIC   = 8'hFF;
	localparam logic [7:0] THREE_MIN     = 8'h14;
	localparam logic [7:0] ANY_LOW_BYTE  = 8'h09;
	localparam logic [7:0] ZERO_BYTE     = 8'h00;

	// Encoded lengths in bytes.
	localparam logic [2:0] LEN_NONE  = 3'd0;
	localparam logic [2:0] LEN_ONE   = 3'd1;
	localparam logic [2:0] LEN_TWO   = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FIVE  = 3'd5;

	// Status codes.
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
	localparam logic [1:0] STATUS_BELOW   = 2'd2;

	// Decoder state between bytes.
	typedef struct packed {
		logic        collecting;
		logic [2:0]  seen;
		logic [2:0]  expected;
		logic [7:0]  desc;
		logic [39:0] buffer;
	} sasd_state_t;

	// One result item.
	typedef struct packed {
		logic [39:0] address_value;
		logic [2:0]  length_bytes;
		logic [1:0]  status_code;
		logic        public_flag;
		logic        any_flag;
	} sasd_result_t;

endpackage

### rtl/short_address_stream_decoder_unit.sv
// Top level of the short address stream decoder.
`timescale 1ns / 1ps

// Short address stream decoder.
// Header bytes enter on the input channel (in_valid, in_stall, data_byte,
// start_flag), one item per byte; start_flag marks the descriptor byte and
// drops any partial address. When an address completes, or is found to be
// malformed, one result item leaves on the output channel (out_valid,
// out_stall, address_value, length_bytes, status_code, public_flag,
// any_flag). Bytes that complete nothing give no result.
// One byte is accepted every cycle while in_stall is low: the decode state
// is updated in the cycle the byte is taken, and its result is registered
// in the output register, or in a one-entry skid register behind it, so the
// block keeps taking bytes while a result waits. Only when both hold results
// does in_stall rise, and it falls again once the receiver takes a result.
// Reset clears the decode state and both result valid flags; the block then
// waits for a descriptor byte and ignores stray bytes until one arrives.
module short_address_stream_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        start_flag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [39:0] address_value,
	output logic [2:0]  length_bytes,
	output logic [1:0]  status_code,
	output logic        public_flag,
	output logic        any_flag
);

	sasd_pkg::sasd_state_t  state_q;
	sasd_pkg::sasd_state_t  state_next;
	sasd_pkg::sasd_result_t step_res;
	sasd_pkg::sasd_result_t out_res_q;
	sasd_pkg::sasd_result_t skid_res_q;
	logic                   step_emit;
	logic                   out_valid_q;
	logic                   skid_valid_q;
	logic                   in_take;
	logic                   out_free;
	logic                   new_res;

	sasd_step u_step (
		.cur        (state_q),
		.data_byte  (data_byte),
		.start_flag (start_flag),
		.nxt        (state_next),
		.emit       (step_emit),
		.res        (step_res)
	);

	// The skid register only fills while the output register is held.
	assign in_stall = skid_valid_q;
	assign in_take  = in_valid && !skid_valid_q;
	assign new_res  = in_take && step_emit;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= '0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				state_q <= state_next;
			end
			if (out_free) begin
				out_valid_q  <= skid_valid_q || new_res;
				skid_valid_q <= 1'b0;
			end else if (new_res) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Result payload carries no reset.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_res_q <= skid_res_q;
			end else if (new_res) begin
				out_res_q <= step_res;
			end
		end else if (new_res) begin
			skid_res_q <= step_res;
		end
	end

	assign out_valid     = out_valid_q;
	assign address_value = out_res_q.address_value;
	assign length_bytes  = out_res_q.length_bytes;
	assign status_code   = out_res_q.status_code;
	assign public_flag   = out_res_q.public_flag;
	assign any_flag      = out_res_q.any_flag;

	// A waiting skid entry always sits behind a held output.
	assert property (@(posedge clk) disable iff (!arst_n) skid_valid_q |-> out_valid_q)
		else $error("skid entry without output entry");

	// A partial address never has all its bytes yet.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.collecting |-> (state_q.seen < state_q.expected))
		else $error("partial address already complete");

	// A valid result has a length, an error result has none.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_res_q.status_code == sasd_pkg::STATUS_OK)
		== (out_res_q.length_bytes != sasd_pkg::LEN_NONE)))
		else $error("status and length disagree");

endmodule

### rtl/sasd_step.sv
// Next-state and result logic for one header byte.
`timescale 1ns / 1ps

module sasd_step (
	input  sasd_pkg::sasd_state_t  cur,
	input  logic [7:0]             data_byte,
	input  logic                   start_flag,
	output sasd_pkg::sasd_state_t  nxt,
	output logic                   emit,
	output sasd_pkg::sasd_result_t res
);

	function automatic sasd_pkg::sasd_result_t make_result(input logic [39:0] value,
		input logic [2:0] len, input logic [1:0] status);
		sasd_pkg::sasd_result_t r;
		r.address_value = value;
		r.length_bytes  = len;
		r.status_code   = status;
		r.public_flag   = (len == sasd_pkg::LEN_TWO) && (value[15:8] == sasd_pkg::DESC_PUBLIC);
		r.any_flag      = (len == sasd_pkg::LEN_TWO) &&
			(value == {24'd0, sasd_pkg::DESC_PUBLIC, sasd_pkg::ANY_LOW_BYTE});
		return r;
	endfunction

	always_comb begin
		logic [39:0] shifted;
		logic [2:0]  seen_next;
		nxt       = cur;
		emit      = 1'b0;
		res       = make_result(40'd0, sasd_pkg::LEN_NONE, sasd_pkg::STATUS_OK);
		shifted   = {cur.buffer[31:0], data_byte};
		seen_next = cur.seen + 3'd1;

		if (start_flag) begin
			nxt            = '0;
			nxt.collecting = 1'b1;
			nxt.seen       = 3'd1;
			nxt.desc       = data_byte;
			nxt.buffer     = {32'd0, data_byte};
			if (data_byte <= sasd_pkg::DESC_ONE_MAX) begin
				nxt  = '0;
				emit = 1'b1;
				res  = make_result({32'd0, data_byte}, sasd_pkg::LEN_ONE, sasd_pkg::STATUS_OK);
			end else if ((data_byte >= sasd_pkg::DESC_TWO_MIN && data_byte <= sasd_pkg::DESC_TWO_MAX)
				|| data_byte == sasd_pkg::DESC_PUBLIC) begin
				nxt.expected = sasd_pkg::LEN_TWO;
			end else if (data_byte == sasd_pkg::DESC_THREE) begin
				nxt.expected = sasd_pkg::LEN_THREE;
			end else if (data_byte == sasd_pkg::DESC_FIVE) begin
				nxt.expected = sasd_pkg::LEN_FIVE;
			end else begin
				nxt  = '0;
				emit = 1'b1;
				res  = make_result(40'd0, sasd_pkg::LEN_NONE, sasd_pkg::STATUS_UNKNOWN);
			end
		end else if (cur.collecting) begin
			nxt.seen   = seen_next;
			nxt.buffer = shifted;
			// Overlong forms are caught on the first byte that shows them.
			if ((seen_next == 3'd2 && ((cur.desc == sasd_pkg::DESC_TWO_MIN
				&& data_byte < sasd_pkg::DESC_TWO_MIN)
				|| (cur.desc == sasd_pkg::DESC_THREE && data_byte < sasd_pkg::THREE_MIN)))
				|| (seen_next == 3'd3 && cur.desc == sasd_pkg::DESC_FIVE
				&& cur.buffer[7:0] == sasd_pkg::ZERO_BYTE && data_byte == sasd_pkg::ZERO_BYTE)) begin
				nxt  = '0;
				emit = 1'b1;
				res  = make_result(40'd0, sasd_pkg::LEN_NONE, sasd_pkg::STATUS_BELOW);
			end else if (seen_next >= cur.expected) begin
				nxt  = '0;
				emit = 1'b1;
				res  = make_result(shifted, cur.expected, sasd_pkg::STATUS_OK);
			end
		end
	end

endmodule
